### sv/pwm_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Partial window mapper package
// Shared widths, defaults, null-window constants and record types.
// ----------------------------------------------------------------------------
package pwm_pkg;

  localparam int unsigned PANEL_WIDTH  = 1200;
  localparam int unsigned PANEL_HEIGHT = 1600;

  // clipped coordinates stay within 0..4096
  localparam int unsigned COORD_W = 13;
  // widened input arithmetic: 18-bit sums and differences
  localparam int unsigned SUM_W   = 18;

  localparam int unsigned QUEUE_DEPTH = 2;

  localparam int unsigned COL_W   = 11;
  localparam int unsigned ROW_W   = 10;
  localparam int unsigned BYTES_W = 9;
  localparam int unsigned OFF_W   = 10;
  localparam int unsigned BROW_W  = 11;

  // null window for a half that takes no part
  localparam logic [COL_W-1:0]   NULL_COL_FIRST  = 11'h000;
  localparam logic [COL_W-1:0]   NULL_COL_LAST   = 11'h007;
  localparam logic [ROW_W-1:0]   NULL_ROW_FIRST  = 10'h000;
  localparam logic [ROW_W-1:0]   NULL_ROW_LAST   = 10'h001;
  localparam logic [BYTES_W-1:0] NULL_ROW_BYTES  = 9'd2;
  localparam logic [BROW_W-1:0]  NULL_BROW_FIRST = 11'd0;
  localparam logic [BROW_W-1:0]  NULL_BROW_LAST  = 11'd3;

  typedef enum logic [1:0] {
    ROT_0   = 2'd0,
    ROT_90  = 2'd1,
    ROT_180 = 2'd2,
    ROT_270 = 2'd3
  } rot_e;

  typedef logic [COORD_W-1:0] coord_t;

  typedef struct packed {
    logic   empty;
    coord_t x;
    coord_t y;
    coord_t w;
    coord_t h;
  } clip_t;

  typedef struct packed {
    logic   empty;
    coord_t cs;
    coord_t ce;
    coord_t rs;
    coord_t re;
  } job_t;

  typedef struct packed {
    logic               nothing;
    logic               half;
    logic [COL_W-1:0]   col_first;
    logic [COL_W-1:0]   col_last;
    logic [ROW_W-1:0]   row_first;
    logic [ROW_W-1:0]   row_last;
    logic [BYTES_W-1:0] row_bytes;
    logic [OFF_W-1:0]   byte_offset;
    logic [BROW_W-1:0]  brow_first;
    logic [BROW_W-1:0]  brow_last;
    logic               last;
  } res_t;

endpackage
`default_nettype wire

### sv/pwm_ram.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Job queue
// Small register FIFO between the classifying front and the emitting back.
// ----------------------------------------------------------------------------
module pwm_fifo #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 2
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             push_i,
  input  wire logic [Width-1:0] data_i,
  output logic                  full_o,
  input  wire logic             pop_i,
  output logic                  valid_o,
  output logic      [Width-1:0] data_o
);

  localparam int unsigned AW   = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);

  logic [Width-1:0] mem_q [Depth];
  logic [AW-1:0]    wr_ptr_q, wr_ptr_d;
  logic [AW-1:0]    rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0]  count_q, count_d;
  logic             do_push, do_pop;

  assign full_o  = (count_q == CntW'(Depth));
  assign valid_o = (count_q != '0);
  assign data_o  = mem_q[rd_ptr_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && valid_o;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == AW'(Depth - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == AW'(Depth - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      count_d = count_q + 1'b1;
    end else if (do_pop && !do_push) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= data_i;
    end
  end

endmodule
`default_nettype wire

### sv/pwm_front.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Mapper front end
// Clips the rectangle to the logical screen, then maps it to aligned
// panel-native column and row bounds. Two register stages.
// ----------------------------------------------------------------------------
module pwm_front #(
  parameter int unsigned PanelWidth  = pwm_pkg::PANEL_WIDTH,
  parameter int unsigned PanelHeight = pwm_pkg::PANEL_HEIGHT
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire pwm_pkg::rot_e      rotation_i,
  input  wire logic               in_valid_i,
  output logic                    in_stall_o,
  input  wire logic signed [15:0] rect_x_i,
  input  wire logic signed [15:0] rect_y_i,
  input  wire logic signed [15:0] rect_w_i,
  input  wire logic signed [15:0] rect_h_i,
  output logic                    job_valid_o,
  output pwm_pkg::job_t           job_o,
  input  wire logic               job_full_i
);

  localparam int unsigned SW = pwm_pkg::SUM_W;
  localparam int unsigned CW = pwm_pkg::COORD_W;

  localparam logic signed [SW-1:0] LwPw = SW'(PanelWidth);
  localparam logic signed [SW-1:0] LwPh = SW'(PanelHeight);
  localparam pwm_pkg::coord_t      Pw   = CW'(PanelWidth);
  localparam pwm_pkg::coord_t      Ph   = CW'(PanelHeight);

  logic           s1_valid_q;
  pwm_pkg::clip_t s1_q, s1_d;
  logic           s2_valid_q;
  pwm_pkg::job_t  s2_q, s2_d;
  logic           s1_adv, s2_load;

  assign s2_load     = !s2_valid_q || !job_full_i;
  assign s1_adv      = !s1_valid_q || s2_load;
  assign in_stall_o  = !s1_adv;
  assign job_valid_o = s2_valid_q;
  assign job_o       = s2_q;

  // stage 1: clip
  logic                 odd;
  logic signed [SW-1:0] x_s, y_s, w_s, h_s, lw, lh;
  logic signed [SW-1:0] xe, ye, xa, ya, wa, ha, wb, hb;

  always_comb begin
    odd = (rotation_i == pwm_pkg::ROT_90) || (rotation_i == pwm_pkg::ROT_270);
    lw  = odd ? LwPh : LwPw;
    lh  = odd ? LwPw : LwPh;
    x_s = SW'(rect_x_i);
    y_s = SW'(rect_y_i);
    w_s = SW'(rect_w_i);
    h_s = SW'(rect_h_i);
    // right edge is x+w whether or not the left edge gets pulled in
    xe  = x_s + w_s;
    ye  = y_s + h_s;
    xa  = x_s[SW-1] ? '0 : x_s;
    ya  = y_s[SW-1] ? '0 : y_s;
    wa  = x_s[SW-1] ? xe : w_s;
    ha  = y_s[SW-1] ? ye : h_s;
    wb  = (xe > lw) ? lw - xa : wa;
    hb  = (ye > lh) ? lh - ya : ha;
    s1_d.empty = wb[SW-1] || (wb == '0) || hb[SW-1] || (hb == '0);
    s1_d.x     = xa[CW-1:0];
    s1_d.y     = ya[CW-1:0];
    s1_d.w     = wb[CW-1:0];
    s1_d.h     = hb[CW-1:0];
  end

  // stage 2: rotate and align
  pwm_pkg::coord_t cs, ce, rs, re, ce_o, re_o;

  always_comb begin
    unique case (rotation_i)
      pwm_pkg::ROT_0: begin
        cs = s1_q.x;
        ce = s1_q.x + s1_q.w - 1'b1;
        rs = s1_q.y;
        re = s1_q.y + s1_q.h - 1'b1;
      end
      pwm_pkg::ROT_90: begin
        cs = Pw - s1_q.y - s1_q.h;
        ce = Pw - 1'b1 - s1_q.y;
        rs = s1_q.x;
        re = s1_q.x + s1_q.w - 1'b1;
      end
      pwm_pkg::ROT_180: begin
        cs = Pw - s1_q.x - s1_q.w;
        ce = Pw - 1'b1 - s1_q.x;
        rs = Ph - s1_q.y - s1_q.h;
        re = Ph - 1'b1 - s1_q.y;
      end
      pwm_pkg::ROT_270: begin
        cs = s1_q.y;
        ce = s1_q.y + s1_q.h - 1'b1;
        rs = Ph - s1_q.x - s1_q.w;
        re = Ph - 1'b1 - s1_q.x;
      end
      default: begin
        cs = '0;
        ce = '0;
        rs = '0;
        re = '0;
      end
    endcase
    ce_o       = ce | CW'(3);
    re_o       = re | CW'(1);
    s2_d.empty = s1_q.empty;
    s2_d.cs    = {cs[CW-1:2], 2'b00};
    s2_d.ce    = (ce_o >= Pw) ? Pw - 1'b1 : ce_o;
    s2_d.rs    = {rs[CW-1:1], 1'b0};
    s2_d.re    = (re_o >= Ph) ? Ph - 1'b1 : re_o;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
      s2_valid_q <= 1'b0;
    end else begin
      if (s1_adv) begin
        s1_valid_q <= in_valid_i;
      end
      if (s2_load) begin
        s2_valid_q <= s1_valid_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_adv && in_valid_i) begin
      s1_q <= s1_d;
    end
    if (s2_load && s1_valid_q) begin
      s2_q <= s2_d;
    end
  end

endmodule
`default_nettype wire

### sv/pwm_back.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Mapper back end
// Splits an aligned window between the two controller halves and emits one
// result per cycle into the output register while the output is not stalled.
// ----------------------------------------------------------------------------
module pwm_back #(
  parameter int unsigned PanelWidth = pwm_pkg::PANEL_WIDTH
) (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          job_valid_i,
  input  wire pwm_pkg::job_t job_i,
  output logic               job_pop_o,
  output logic               out_valid_o,
  input  wire logic          out_stall_i,
  output pwm_pkg::res_t      res_o
);

  localparam int unsigned CW     = pwm_pkg::COORD_W;
  localparam int unsigned HalfI  = PanelWidth / 2;
  localparam int unsigned HalfBI = HalfI / 2;
  localparam pwm_pkg::coord_t Half  = CW'(HalfI);
  localparam pwm_pkg::coord_t HalfB = CW'(HalfBI);

  logic            out_valid_q;
  pwm_pkg::res_t   res_q, res_d;
  logic            phase_q;
  logic            load, take;
  logic            inv;
  pwm_pkg::coord_t lcs, lce, base, span, reh, rowl;

  assign load        = !out_valid_q || !out_stall_i;
  assign take        = job_valid_i && load;
  assign job_pop_o   = take && (job_i.empty || phase_q);
  assign out_valid_o = out_valid_q;
  assign res_o       = res_q;

  always_comb begin
    if (phase_q) begin
      inv  = (job_i.ce >= Half);
      lcs  = (job_i.cs >= Half) ? job_i.cs - Half : '0;
      lce  = job_i.ce - Half;
      base = HalfB;
    end else begin
      inv  = (job_i.cs < Half);
      lcs  = job_i.cs;
      lce  = (job_i.ce < Half) ? job_i.ce : Half - 1'b1;
      base = '0;
    end
    span = lce - lcs + 1'b1;
    reh  = job_i.re + 1'b1;
    rowl = (reh >> 1) - 1'b1;

    res_d         = '0;
    res_d.half    = phase_q;
    res_d.last    = phase_q;
    if (job_i.empty) begin
      res_d.nothing = 1'b1;
      res_d.half    = 1'b0;
      res_d.last    = 1'b1;
    end else if (inv) begin
      res_d.col_first   = pwm_pkg::COL_W'({lcs, 1'b0});
      res_d.col_last    = pwm_pkg::COL_W'({lce, 1'b1});
      res_d.row_first   = pwm_pkg::ROW_W'(job_i.rs >> 1);
      res_d.row_last    = pwm_pkg::ROW_W'(rowl);
      res_d.row_bytes   = pwm_pkg::BYTES_W'(span >> 1);
      res_d.byte_offset = pwm_pkg::OFF_W'(base + (lcs >> 1));
      res_d.brow_first  = pwm_pkg::BROW_W'(job_i.rs);
      res_d.brow_last   = pwm_pkg::BROW_W'(job_i.re);
    end else begin
      res_d.col_first   = pwm_pkg::NULL_COL_FIRST;
      res_d.col_last    = pwm_pkg::NULL_COL_LAST;
      res_d.row_first   = pwm_pkg::NULL_ROW_FIRST;
      res_d.row_last    = pwm_pkg::NULL_ROW_LAST;
      res_d.row_bytes   = pwm_pkg::NULL_ROW_BYTES;
      res_d.byte_offset = pwm_pkg::OFF_W'(base);
      res_d.brow_first  = pwm_pkg::NULL_BROW_FIRST;
      res_d.brow_last   = pwm_pkg::NULL_BROW_LAST;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      phase_q     <= 1'b0;
    end else begin
      if (load) begin
        out_valid_q <= job_valid_i;
      end
      if (take) begin
        phase_q <= !job_pop_o;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) begin
      res_q <= res_d;
    end
  end

endmodule
`default_nettype wire

### sv/partial_window_mapper_top.sv
`timescale 1ns / 1ps
`default_nettype none
// Path: each input passes the front-end clip and align registers, the job queue
// and the output register; the slave result follows the master result.
// Throughput: a drawable rectangle gives two results through the single output
// register; empty rectangles go one per cycle while the output is not stalled.
// Reset: rotation returns to 0 and all pipeline, queue and output state empties.
// ----------------------------------------------------------------------------
// Partial window mapper top level
// Rotation register, clip/map front end, job queue and half-splitting back end.
// ----------------------------------------------------------------------------
module partial_window_mapper_top #(
  parameter int unsigned PanelWidth  = pwm_pkg::PANEL_WIDTH,
  parameter int unsigned PanelHeight = pwm_pkg::PANEL_HEIGHT
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          cfg_we_i,
  input  wire logic [1:0]                    cfg_data_i,
  input  wire logic                          in_valid_i,
  output logic                               in_stall_o,
  input  wire logic signed [15:0]            rect_x_i,
  input  wire logic signed [15:0]            rect_y_i,
  input  wire logic signed [15:0]            rect_w_i,
  input  wire logic signed [15:0]            rect_h_i,
  output logic                               out_valid_o,
  input  wire logic                          out_stall_i,
  output logic                               nothing_to_draw_o,
  output logic                               chip_half_o,
  output logic [pwm_pkg::COL_W-1:0]          win_col_first_o,
  output logic [pwm_pkg::COL_W-1:0]          win_col_last_o,
  output logic [pwm_pkg::ROW_W-1:0]          win_row_first_o,
  output logic [pwm_pkg::ROW_W-1:0]          win_row_last_o,
  output logic [pwm_pkg::BYTES_W-1:0]        row_bytes_o,
  output logic [pwm_pkg::OFF_W-1:0]          buffer_byte_offset_o,
  output logic [pwm_pkg::BROW_W-1:0]         buffer_row_first_o,
  output logic [pwm_pkg::BROW_W-1:0]         buffer_row_last_o,
  output logic                               last_result_o
);

  localparam int unsigned JobW = $bits(pwm_pkg::job_t);

  pwm_pkg::rot_e rotation_q;
  logic          front_valid, q_full, q_valid, q_pop;
  pwm_pkg::job_t front_job;
  logic [JobW-1:0] q_data;
  pwm_pkg::res_t res;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rotation_q <= pwm_pkg::ROT_0;
    end else if (cfg_we_i) begin
      rotation_q <= pwm_pkg::rot_e'(cfg_data_i);
    end
  end

  pwm_front #(
    .PanelWidth (PanelWidth),
    .PanelHeight(PanelHeight)
  ) u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .rotation_i (rotation_q),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .rect_x_i   (rect_x_i),
    .rect_y_i   (rect_y_i),
    .rect_w_i   (rect_w_i),
    .rect_h_i   (rect_h_i),
    .job_valid_o(front_valid),
    .job_o      (front_job),
    .job_full_i (q_full)
  );

  pwm_fifo #(
    .Width(JobW),
    .Depth(pwm_pkg::QUEUE_DEPTH)
  ) u_queue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (front_valid),
    .data_i (front_job),
    .full_o (q_full),
    .pop_i  (q_pop),
    .valid_o(q_valid),
    .data_o (q_data)
  );

  pwm_back #(
    .PanelWidth(PanelWidth)
  ) u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .job_valid_i(q_valid),
    .job_i      (pwm_pkg::job_t'(q_data)),
    .job_pop_o  (q_pop),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .res_o      (res)
  );

  assign nothing_to_draw_o    = res.nothing;
  assign chip_half_o          = res.half;
  assign win_col_first_o      = res.col_first;
  assign win_col_last_o       = res.col_last;
  assign win_row_first_o      = res.row_first;
  assign win_row_last_o       = res.row_last;
  assign row_bytes_o          = res.row_bytes;
  assign buffer_byte_offset_o = res.byte_offset;
  assign buffer_row_first_o   = res.brow_first;
  assign buffer_row_last_o    = res.brow_last;
  assign last_result_o        = res.last;

endmodule
`default_nettype wire

### sv/pwm_checker.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Mapper port checker
// Result sequencing rules seen on the output port of the top level.
// ----------------------------------------------------------------------------
module pwm_checker (
  input wire logic                        clk_i,
  input wire logic                        rst_ni,
  input wire logic                        out_valid_o,
  input wire logic                        out_stall_i,
  input wire logic                        nothing_to_draw_o,
  input wire logic                        chip_half_o,
  input wire logic [pwm_pkg::COL_W-1:0]   win_col_first_o,
  input wire logic [pwm_pkg::COL_W-1:0]   win_col_last_o,
  input wire logic [pwm_pkg::BYTES_W-1:0] row_bytes_o,
  input wire logic [pwm_pkg::BROW_W-1:0]  buffer_row_first_o,
  input wire logic                        last_result_o
);

  // empty rectangle: a single, final result with zero fields
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && nothing_to_draw_o |->
      last_result_o && !chip_half_o && (win_col_last_o == '0) && (row_bytes_o == '0))
    else $error("empty result not final or not cleared");

  // drawable: master half first, slave half last
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !nothing_to_draw_o |-> (chip_half_o == last_result_o))
    else $error("half and last flag disagree");

  // the slave result follows a master transfer straight away
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_stall_i && !last_result_o |=>
      out_valid_o && last_result_o && chip_half_o && !nothing_to_draw_o)
    else $error("slave result missing after master transfer");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=>
      out_valid_o && $stable(win_col_first_o) && $stable(buffer_row_first_o)
      && $stable(last_result_o))
    else $error("stalled result changed");

endmodule

bind partial_window_mapper_top pwm_checker u_pwm_checker (.*);
`default_nettype wire

### tb/sv/partial_window_mapper_top_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Partial window mapper testbench
// Drives rectangles under all four rotations with random gaps and output
// stalls, predicts the per-half window records and checks every transfer.
// ----------------------------------------------------------------------------
module partial_window_mapper_top_tb;
  import pwm_pkg::*;

  localparam int PW         = PANEL_WIDTH;
  localparam int PH         = PANEL_HEIGHT;
  localparam int HALF_COLS  = PW / 2;
  localparam int SLAVE_BYTE_BASE = HALF_COLS / 2;
  localparam int IDLE_LIMIT = 2000;
  localparam int HOLD_CYCLES = 80;
  localparam int RANDOM_PER_PHASE = 110;

  class window_scoreboard;
    rot_e        rotation;
    res_t        pending_windows[$];
    int unsigned errors;

    function new();
      rotation = ROT_0;
      errors   = 0;
    endfunction

    function int pending();
      return pending_windows.size();
    endfunction

    task report(input string what, input longint got_v, input longint exp_v);
      errors++;
      if (errors <= 40) begin
        $display("mismatch %0d at %0t: %s got %0d exp %0d", errors, $realtime, what,
                 got_v, exp_v);
      end
    endtask

    function res_t make_window(input logic half, input int cf, input int cl, input int rf,
                               input int rl, input int bytes, input int off, input int bf,
                               input int bl, input logic last);
      res_t r;
      r.nothing     = 1'b0;
      r.half        = half;
      r.col_first   = COL_W'(cf);
      r.col_last    = COL_W'(cl);
      r.row_first   = ROW_W'(rf);
      r.row_last    = ROW_W'(rl);
      r.row_bytes   = BYTES_W'(bytes);
      r.byte_offset = OFF_W'(off);
      r.brow_first  = BROW_W'(bf);
      r.brow_last   = BROW_W'(bl);
      r.last        = last;
      return r;
    endfunction

    // clip, rotate, align, then split between the two controller halves
    function void map_to_windows(input int rx, input int ry, input int rw, input int rh);
      int   x, y, w, h, lw, lh, cs, ce, rs, re, lcs, lce;
      res_t empty_res;
      x  = rx;
      y  = ry;
      w  = rw;
      h  = rh;
      lw = (rotation == ROT_90 || rotation == ROT_270) ? PH : PW;
      lh = (rotation == ROT_90 || rotation == ROT_270) ? PW : PH;
      if (x < 0) begin
        w += x;
        x = 0;
      end
      if (y < 0) begin
        h += y;
        y = 0;
      end
      if (x + w > lw) w = lw - x;
      if (y + h > lh) h = lh - y;
      if (w <= 0 || h <= 0) begin
        empty_res         = '0;
        empty_res.nothing = 1'b1;
        empty_res.last    = 1'b1;
        pending_windows.push_back(empty_res);
        return;
      end
      case (rotation)
        ROT_0: begin
          cs = x;          ce = x + w - 1;  rs = y;          re = y + h - 1;
        end
        ROT_90: begin
          cs = PW - y - h; ce = PW - 1 - y; rs = x;          re = x + w - 1;
        end
        ROT_180: begin
          cs = PW - x - w; ce = PW - 1 - x; rs = PH - y - h; re = PH - 1 - y;
        end
        default: begin
          cs = y;          ce = y + h - 1;  rs = PH - x - w; re = PH - 1 - x;
        end
      endcase
      // columns to whole groups of 4, rows to even bounds
      cs = (cs / 4) * 4;
      ce = ((ce + 4) / 4) * 4 - 1;
      if (ce >= PW) ce = PW - 1;
      if (rs % 2 != 0) rs--;
      if (rs < 0) rs = 0;
      if ((re + 1) % 2 != 0) re++;
      if (re >= PH) re = PH - 1;

      if (cs < HALF_COLS) begin
        lce = (ce < HALF_COLS) ? ce : HALF_COLS - 1;
        pending_windows.push_back(make_window(1'b0, cs * 2, (lce + 1) * 2 - 1, rs / 2,
                                              (re + 1) / 2 - 1, (lce - cs + 1) / 2, cs / 2,
                                              rs, re, 1'b0));
      end else begin
        pending_windows.push_back(make_window(1'b0, NULL_COL_FIRST, NULL_COL_LAST,
                                              NULL_ROW_FIRST, NULL_ROW_LAST, NULL_ROW_BYTES,
                                              0, NULL_BROW_FIRST, NULL_BROW_LAST, 1'b0));
      end
      if (ce >= HALF_COLS) begin
        lcs = (cs >= HALF_COLS) ? cs - HALF_COLS : 0;
        lce = ce - HALF_COLS;
        pending_windows.push_back(make_window(1'b1, lcs * 2, (lce + 1) * 2 - 1, rs / 2,
                                              (re + 1) / 2 - 1, (lce - lcs + 1) / 2,
                                              SLAVE_BYTE_BASE + lcs / 2, rs, re, 1'b1));
      end else begin
        pending_windows.push_back(make_window(1'b1, NULL_COL_FIRST, NULL_COL_LAST,
                                              NULL_ROW_FIRST, NULL_ROW_LAST, NULL_ROW_BYTES,
                                              SLAVE_BYTE_BASE, NULL_BROW_FIRST, NULL_BROW_LAST,
                                              1'b1));
      end
    endfunction

    task check_result(input res_t got);
      res_t exp;
      if (pending_windows.size() == 0) begin
        report("result with nothing outstanding", 1, 0);
        return;
      end
      exp = pending_windows.pop_front();
      if (got.nothing !== exp.nothing)     report("nothing_to_draw", got.nothing, exp.nothing);
      if (got.half !== exp.half)           report("chip_half", got.half, exp.half);
      if (got.col_first !== exp.col_first) report("win_col_first", got.col_first, exp.col_first);
      if (got.col_last !== exp.col_last)   report("win_col_last", got.col_last, exp.col_last);
      if (got.row_first !== exp.row_first) report("win_row_first", got.row_first, exp.row_first);
      if (got.row_last !== exp.row_last)   report("win_row_last", got.row_last, exp.row_last);
      if (got.row_bytes !== exp.row_bytes) report("row_bytes", got.row_bytes, exp.row_bytes);
      if (got.byte_offset !== exp.byte_offset) begin
        report("buffer_byte_offset", got.byte_offset, exp.byte_offset);
      end
      if (got.brow_first !== exp.brow_first) begin
        report("buffer_row_first", got.brow_first, exp.brow_first);
      end
      if (got.brow_last !== exp.brow_last) report("buffer_row_last", got.brow_last, exp.brow_last);
      if (got.last !== exp.last)           report("last_result", got.last, exp.last);
    endtask
  endclass

  logic               clk_i;
  logic               rst_ni;
  logic               cfg_we_i;
  logic [1:0]         cfg_data_i;
  logic               in_valid_i;
  logic               in_stall_o;
  logic signed [15:0] rect_x_i;
  logic signed [15:0] rect_y_i;
  logic signed [15:0] rect_w_i;
  logic signed [15:0] rect_h_i;
  logic               out_valid_o;
  logic               out_stall_i;
  logic               nothing_to_draw_o;
  logic               chip_half_o;
  logic [COL_W-1:0]   win_col_first_o;
  logic [COL_W-1:0]   win_col_last_o;
  logic [ROW_W-1:0]   win_row_first_o;
  logic [ROW_W-1:0]   win_row_last_o;
  logic [BYTES_W-1:0] row_bytes_o;
  logic [OFF_W-1:0]   buffer_byte_offset_o;
  logic [BROW_W-1:0]  buffer_row_first_o;
  logic [BROW_W-1:0]  buffer_row_last_o;
  logic               last_result_o;

  window_scoreboard sb = new();

  logic gaps_on;
  logic stall_on;
  logic hold_req;
  int   hold_left;
  int   quiet_cycles;
  logic moved;
  res_t got_res;

  partial_window_mapper_top i_dut (
    .clk_i                (clk_i),
    .rst_ni               (rst_ni),
    .cfg_we_i             (cfg_we_i),
    .cfg_data_i           (cfg_data_i),
    .in_valid_i           (in_valid_i),
    .in_stall_o           (in_stall_o),
    .rect_x_i             (rect_x_i),
    .rect_y_i             (rect_y_i),
    .rect_w_i             (rect_w_i),
    .rect_h_i             (rect_h_i),
    .out_valid_o          (out_valid_o),
    .out_stall_i          (out_stall_i),
    .nothing_to_draw_o    (nothing_to_draw_o),
    .chip_half_o          (chip_half_o),
    .win_col_first_o      (win_col_first_o),
    .win_col_last_o       (win_col_last_o),
    .win_row_first_o      (win_row_first_o),
    .win_row_last_o       (win_row_last_o),
    .row_bytes_o          (row_bytes_o),
    .buffer_byte_offset_o (buffer_byte_offset_o),
    .buffer_row_first_o   (buffer_row_first_o),
    .buffer_row_last_o    (buffer_row_last_o),
    .last_result_o        (last_result_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  // receiver: random stalls, plus one long hold-off on request
  always @(negedge clk_i) begin
    if (hold_req) begin
      hold_req  = 1'b0;
      hold_left = HOLD_CYCLES;
    end
    out_stall_i <= (hold_left > 0) || (stall_on && $urandom_range(99) < 37);
    if (hold_left > 0) hold_left--;
  end

  // transfer monitor and watchdog
  always @(posedge clk_i) begin
    if (rst_ni) begin
      moved = 1'b0;
      if (in_valid_i && !in_stall_o) begin
        sb.map_to_windows(rect_x_i, rect_y_i, rect_w_i, rect_h_i);
        moved = 1'b1;
      end
      if (out_valid_o && !out_stall_i) begin
        got_res = {nothing_to_draw_o, chip_half_o, win_col_first_o, win_col_last_o,
                   win_row_first_o, win_row_last_o, row_bytes_o, buffer_byte_offset_o,
                   buffer_row_first_o, buffer_row_last_o, last_result_o};
        sb.check_result(got_res);
        moved = 1'b1;
      end
      quiet_cycles = moved ? 0 : quiet_cycles + 1;
      if (quiet_cycles >= IDLE_LIMIT) begin
        $display("RESULT: ERROR");
        $finish;
      end
    end
  end

  // called at a falling edge, returns at the falling edge after the transfer
  task automatic send_rect(input int x, input int y, input int w, input int h);
    while (gaps_on && $urandom_range(99) < 37) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    rect_x_i   <= 16'(x);
    rect_y_i   <= 16'(y);
    rect_w_i   <= 16'(w);
    rect_h_i   <= 16'(h);
    @(posedge clk_i);
    while (in_stall_o !== 1'b0) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  task automatic set_rotation(input rot_e rot);
    in_valid_i <= 1'b0;
    while (sb.pending() != 0) @(negedge clk_i);
    cfg_we_i   <= 1'b1;
    cfg_data_i <= rot;
    @(negedge clk_i);
    cfg_we_i    <= 1'b0;
    sb.rotation = rot;
  endtask

  task automatic run_directed(input rot_e rot);
    int lw, lh;
    lw = (rot == ROT_90 || rot == ROT_270) ? PH : PW;
    lh = (rot == ROT_90 || rot == ROT_270) ? PW : PH;
    send_rect(0, 0, lw, lh);               // whole screen, both halves
    send_rect(1, 3, 5, 7);                 // odd start, one half only
    send_rect(lw - 5, lh - 3, 40, 40);     // clipped at far corner, end clamps
    send_rect(-10, -7, 20, 15);            // negative origin
    send_rect(5, 5, 0, 10);                // zero width
    send_rect(-32768, 32767, 32767, -32768);
    if (rot == ROT_0) send_rect(32767, -32768, -32768, 32767);
  endtask

  task automatic send_random(input rot_e rot);
    int lw, lh, pick, x, y, w, h;
    lw   = (rot == ROT_90 || rot == ROT_270) ? PH : PW;
    lh   = (rot == ROT_90 || rot == ROT_270) ? PW : PH;
    pick = $urandom_range(99);
    x    = int'($urandom_range(0, lw + 70)) - 60;
    y    = int'($urandom_range(0, lh + 70)) - 60;
    w    = ($urandom_range(3) == 0) ? int'($urandom_range(1, lw + 80))
                                    : int'($urandom_range(1, 64));
    h    = ($urandom_range(3) == 0) ? int'($urandom_range(1, lh + 80))
                                    : int'($urandom_range(1, 64));
    if (pick < 15) begin
      // raw 16-bit noise, mostly empty after clipping
      x = $urandom;
      y = $urandom;
      w = $urandom;
      h = $urandom;
    end else if (pick < 27) begin
      if ($urandom_range(1) == 1) begin
        w = -int'($urandom_range(0, 60));
      end else begin
        x = lw + int'($urandom_range(0, 400));
      end
    end
    send_rect(x, y, w, h);
  endtask

  rot_e phase_rot [8] = '{ROT_270, ROT_0, ROT_90, ROT_180, ROT_0, ROT_270, ROT_180, ROT_90};

  initial begin
    rst_ni       = 1'b0;
    cfg_we_i     = 1'b0;
    cfg_data_i   = '0;
    in_valid_i   = 1'b0;
    rect_x_i     = '0;
    rect_y_i     = '0;
    rect_w_i     = '0;
    rect_h_i     = '0;
    out_stall_i  = 1'b0;
    gaps_on      = 1'b1;
    stall_on     = 1'b1;
    hold_req     = 1'b0;
    hold_left    = 0;
    quiet_cycles = 0;
    repeat (6) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    for (int r = 0; r < 4; r++) begin
      set_rotation(rot_e'(r));
      run_directed(rot_e'(r));
    end

    for (int p = 0; p < 8; p++) begin
      set_rotation(phase_rot[p]);
      // one phase runs flat out on both sides
      gaps_on  = (p != 1);
      stall_on = (p != 1);
      if (p == 4) hold_req = 1'b1;
      repeat (RANDOM_PER_PHASE) send_random(phase_rot[p]);
    end

    in_valid_i <= 1'b0;
    while (sb.pending() != 0) @(negedge clk_i);
    repeat (12) @(negedge clk_i);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
